FILE: src/tgeg_pkg.sv
// ----------------------------------------------------------------------------
// tgeg_pkg: shared types and constants of the time-gated energy grouper
// Widths of the time and sum registers, item layouts and the particle
// class decode.
// ----------------------------------------------------------------------------
package tgeg_pkg;

	localparam int TIME_BITS   = 48;
	localparam int SUM_BITS    = 40;
	localparam int GATE_BITS   = 20;
	localparam int ENERGY_BITS = 32;
	localparam int CODE_BITS   = 32;
	localparam int START_BITS  = TIME_BITS + 1;
	localparam int NUM_CLASSES = 4;
	localparam int ACC_BITS    = ((SUM_BITS > ENERGY_BITS) ? SUM_BITS : ENERGY_BITS) + 1;

	localparam int IN_FIELD_BITS  = TIME_BITS + ENERGY_BITS + CODE_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = START_BITS + NUM_CLASSES * SUM_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam logic [GATE_BITS-1:0] GATE_RESET = GATE_BITS'(100);
	localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};
	localparam logic [SUM_BITS-1:0]  SUM_MAX    = {SUM_BITS{1'b1}};

	localparam logic signed [CODE_BITS-1:0] CODE_PHOTON   = 32'sd22;
	localparam logic signed [CODE_BITS-1:0] CODE_ELECTRON = 32'sd11;
	localparam logic signed [CODE_BITS-1:0] CODE_MINUS_1  = -32'sd1;
	localparam logic signed [CODE_BITS-1:0] CODE_MUON     = 32'sd13;
	localparam logic signed [CODE_BITS-1:0] CODE_ANTIMUON = -32'sd13;
	localparam logic signed [CODE_BITS-1:0] CODE_XE_LOW   = 32'sd1000540000;
	localparam logic signed [CODE_BITS-1:0] CODE_XE_HIGH  = 32'sd1000550000;

	typedef enum logic [1:0] {
		CLS_EM    = 2'd0,
		CLS_MUON  = 2'd1,
		CLS_XENON = 2'd2,
		CLS_OTHER = 2'd3
	} class_t;

	function automatic class_t classify(input logic signed [CODE_BITS-1:0] code);
		class_t cls;
		if (code == CODE_PHOTON || code == CODE_ELECTRON || code == CODE_MINUS_1) begin
			cls = CLS_EM;
		end else if (code == CODE_MUON || code == CODE_ANTIMUON) begin
			cls = CLS_MUON;
		end else if (code > CODE_XE_LOW && code < CODE_XE_HIGH) begin
			cls = CLS_XENON;
		end else begin
			cls = CLS_OTHER;
		end
		return cls;
	endfunction

endpackage

FILE: src/time_gated_energy_grouper.sv
// ----------------------------------------------------------------------------
// time_gated_energy_grouper: groups detector hits into time windows
// Sums hit energy per window in four saturating particle classes and
// emits one item per closed or flushed window that holds energy.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  s_*     | s_tvalid/s_tready  | s_tlast = flush, s_tdata = time, energy, code
//  m_*     | m_tvalid/m_tready  | m_tdata = start, em, muon, xenon, other sums
//  cfg_*   | cfg_valid/cfg_ready| cfg_data = gate width in ns
// An input item is registered, then processed against the window state, and
// its result lands in the output register, at one item per cycle unless the
// output stalls. The output register stalls the input register only while a
// result waits and m_tready is low. Reset clears the window state and loads
// a gate width of 100 ns.
// ----------------------------------------------------------------------------
module time_gated_energy_grouper
	import tgeg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // hit_time, hit_energy, particle_code
	input  logic                     s_tlast,   // action: end of event flush
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // window_start, em, muon, xenon, other
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [GATE_BITS-1:0]     cfg_data
);

	logic                        valid_s1;
	logic                        flush_s1;
	logic [TIME_BITS-1:0]        time_s1;
	logic [ENERGY_BITS-1:0]      energy_s1;
	logic signed [CODE_BITS-1:0] code_s1;

	logic [GATE_BITS-1:0] gate_width_q;
	logic [TIME_BITS-1:0] window_end_q;
	logic [SUM_BITS-1:0]  sums_q [NUM_CLASSES];

	logic                     out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;

	logic                 advance;
	logic                 any_sum;
	logic                 open_win;
	logic                 emit;
	logic [TIME_BITS:0]   end_sum;
	logic [TIME_BITS-1:0] end_next;
	logic [SUM_BITS-1:0]  sums_next [NUM_CLASSES];
	logic [SUM_BITS-1:0]  base_sum;
	logic [ACC_BITS-1:0]  acc;
	logic [START_BITS-1:0] start;
	class_t               cls;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			flush_s1  <= s_tlast;
			time_s1   <= s_tdata[TIME_BITS-1:0];
			energy_s1 <= s_tdata[TIME_BITS+ENERGY_BITS-1:TIME_BITS];
			code_s1   <= s_tdata[IN_FIELD_BITS-1:TIME_BITS+ENERGY_BITS];
		end
	end

	always_comb begin
		any_sum = 1'b0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			any_sum = any_sum | (sums_q[i] != '0);
		end
		cls      = classify(code_s1);
		open_win = time_s1 > window_end_q;
		end_sum  = {1'b0, time_s1} + (TIME_BITS+1)'(gate_width_q);
		start    = {1'b0, window_end_q} - START_BITS'(gate_width_q);
		end_next = window_end_q;
		emit     = 1'b0;
		base_sum = '0;
		acc      = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			sums_next[i] = sums_q[i];
		end
		if (flush_s1) begin
			emit     = any_sum;
			end_next = '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				sums_next[i] = '0;
			end
		end else if (energy_s1 != '0) begin
			if (open_win) begin
				emit     = (window_end_q != '0) && any_sum;
				end_next = end_sum[TIME_BITS] ? TIME_MAX : end_sum[TIME_BITS-1:0];
				for (int i = 0; i < NUM_CLASSES; i++) begin
					sums_next[i] = '0;
				end
			end
			base_sum = open_win ? '0 : sums_q[cls];
			acc      = ACC_BITS'(base_sum) + ACC_BITS'(energy_s1);
			sums_next[cls] = (acc > ACC_BITS'(SUM_MAX)) ? SUM_MAX : acc[SUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_width_q <= GATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gate_width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_end_q <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				sums_q[i] <= '0;
			end
		end else if (advance) begin
			window_end_q <= end_next;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				sums_q[i] <= sums_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= OUT_DATA_BITS'({sums_q[CLS_OTHER], sums_q[CLS_XENON],
				sums_q[CLS_MUON], sums_q[CLS_EM], start});
		end
	end

endmodule
